/* src/assert_macros.svh */
// Assertion macros shared by the capture period extender RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPOE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("cpoe assertion failed");
`define CPOE_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("cpoe forbidden condition seen");
`else
`define CPOE_ASSERT(lbl, clk, rstn, prop)
`define CPOE_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* src/cpoe_pkg.sv */
// Types and constants of the capture period overflow extender.
package cpoe_pkg;

  localparam logic REQ_OVERFLOW = 1'b0;
  localparam logic REQ_CAPTURE  = 1'b1;

  localparam int TS_CHANNELS = 2;

  typedef struct packed {
    logic [31:0] last_ovf;
    logic [15:0] last_cap;
  } chan_entry_t;

  typedef struct packed {
    logic [31:0] period;
    logic [47:0] ts;
    chan_entry_t entry;
  } calc_res_t;

endpackage

/* src/cpoe_chan_mem.sv */
// Per-channel state memory with reset-cleared valid bits and registered read.
module cpoe_chan_mem #(
  parameter int NUM_CHANNELS = 4,
  parameter int AW = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output cpoe_pkg::chan_entry_t rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  cpoe_pkg::chan_entry_t wr_data_i
);
  import cpoe_pkg::*;

  chan_entry_t mem_q [NUM_CHANNELS];
  chan_entry_t rd_q;
  logic [NUM_CHANNELS-1:0] vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* src/cpoe_period_calc.sv */
// Period and timestamp arithmetic for one capture word.
module cpoe_period_calc (
  input  logic [31:0]           count_i,
  input  logic [15:0]           cap_i,
  input  logic                  pend_i,
  input  logic                  ts_en_i,
  input  cpoe_pkg::chan_entry_t old_i,
  output cpoe_pkg::calc_res_t   res_o
);
  import cpoe_pkg::*;

  logic [31:0] base;
  logic [31:0] ovf_diff;

  always_comb begin
    base = count_i;
    if (pend_i && (cap_i > old_i.last_cap)) begin
      base = count_i - 32'd1;
    end
    ovf_diff = base - old_i.last_ovf;
    res_o.period = {ovf_diff[15:0], 16'd0} + {16'd0, cap_i} - {16'd0, old_i.last_cap};
    res_o.ts = ts_en_i ? {base[31:0], cap_i} : 48'd0;
    res_o.entry.last_ovf = base;
    res_o.entry.last_cap = cap_i;
  end

endmodule

/* src/capture_period_overflow_extender.sv */
// Top level of the capture period overflow extender.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i/in_ready_o   | req_type, channel, capture_value,
//          |           |                        | overflow_pending
//  out     | output    | out_valid_o/out_ready_i | result_channel, period_ticks,
//          |           |                        | capture_timestamp
//
// One word is accepted per cycle while the output is not stalled. A capture result is registered
// first by the channel memory read, then by the output register.
// Back-to-back captures on one channel use the write-back value forwarded into the read.
// Reset clears the overflow count and the per-entry valid bits at once; no clearing pass.
// A stalled output holds the pipeline; overflow ticks and dropped channels give no word.
module capture_period_overflow_extender #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [1:0]         channel_i,
  input  logic [15:0]        capture_value_i,
  input  logic               overflow_pending_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         result_channel_o,
  output logic signed [31:0] period_ticks_o,
  output logic [47:0]        capture_timestamp_o
);
  import cpoe_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic          in_fire;
  logic          cap_fire;
  logic [AW+1:0] ch_ext;
  logic          ch_ok;
  logic          ts_ok;
  logic          fwd_d;
  logic          s1_adv;
  logic          wr_en;

  logic [31:0]   ovf_cnt_q;
  logic          s1_vld_q;
  logic [AW-1:0] s1_addr_q;
  logic [1:0]    s1_ch_q;
  logic [15:0]   s1_cap_q;
  logic          s1_pend_q;
  logic          s1_ts_q;
  logic [31:0]   s1_cnt_q;
  logic          fwd_q;
  chan_entry_t   fwd_data_q;

  chan_entry_t   rd_data;
  chan_entry_t   old_entry;
  calc_res_t     calc;

  logic          out_vld_q;
  logic [1:0]    out_ch_q;
  logic [31:0]   out_period_q;
  logic [47:0]   out_ts_q;

  assign ch_ext   = {{AW{1'b0}}, channel_i};
  assign ch_ok    = ch_ext < (AW+2)'(NUM_CHANNELS);
  assign ts_ok    = ch_ext < (AW+2)'(TS_CHANNELS);
  assign in_fire  = in_valid_i && in_ready_o;
  assign cap_fire = in_fire && (req_type_i == REQ_CAPTURE) && ch_ok;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign wr_en      = s1_adv;
  assign fwd_d      = cap_fire && wr_en && (s1_addr_q == ch_ext[AW-1:0]);
  assign old_entry  = fwd_q ? fwd_data_q : rd_data;

  cpoe_chan_mem #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .AW          (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (cap_fire),
    .rd_addr_i(ch_ext[AW-1:0]),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(calc.entry)
  );

  cpoe_period_calc u_calc (
    .count_i(s1_cnt_q),
    .cap_i  (s1_cap_q),
    .pend_i (s1_pend_q),
    .ts_en_i(s1_ts_q),
    .old_i  (old_entry),
    .res_o  (calc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire && (req_type_i == REQ_OVERFLOW)) begin
        ovf_cnt_q <= ovf_cnt_q + 32'd1;
      end
      if (in_ready_o) begin
        s1_vld_q <= cap_fire;
      end
      if (!out_vld_q || out_ready_i) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_fire) begin
      s1_addr_q  <= ch_ext[AW-1:0];
      s1_ch_q    <= channel_i;
      s1_cap_q   <= capture_value_i;
      s1_pend_q  <= overflow_pending_i;
      s1_ts_q    <= ts_ok;
      s1_cnt_q   <= ovf_cnt_q;
      fwd_q      <= fwd_d;
      fwd_data_q <= calc.entry;
    end
    if (s1_adv) begin
      out_ch_q     <= s1_ch_q;
      out_period_q <= calc.period;
      out_ts_q     <= calc.ts;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign result_channel_o    = out_ch_q;
  assign period_ticks_o      = $signed(out_period_q);
  assign capture_timestamp_o = out_ts_q;

  `CPOE_ASSERT(a_s1_hold, clk_i, rst_ni, (s1_vld_q && !s1_adv) |=> s1_vld_q)
  `CPOE_ASSERT(a_ovf_count, clk_i, rst_ni, (in_fire && (req_type_i == REQ_OVERFLOW)) |=> (ovf_cnt_q == $past(ovf_cnt_q) + 32'd1))
  `CPOE_NEVER(a_fwd_no_write, clk_i, rst_ni, fwd_d && !s1_vld_q)

endmodule
